// ===== rtl/pis_pkg.sv =====
// Shared types, register codes, widths and the log2 fraction table of the stretch block.
package pis_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int DIFF_W         = 33;
    localparam int POS_W          = 6;
    localparam int LOG_TABLE_BITS = 6;
    localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
    localparam int FRAC_W         = 16;
    localparam int EXP_W          = 5;
    localparam int LG2_W          = EXP_W + FRAC_W;
    localparam int LG10_W         = 20;
    localparam int GAIN_HALF_W    = 16;
    localparam int LIN_PROD_W     = DIFF_W + GAIN_HALF_W;
    localparam int LIN_SUM_W      = LIN_PROD_W + 1;
    localparam int LIN_GRAY_W     = LIN_SUM_W - GAIN_HALF_W;
    localparam int LOG10_PROD_W   = LG2_W + 31;
    localparam int GAIN_PROD_W    = LG10_W + SAMPLE_W;
    localparam int LOG_GRAY_W     = GAIN_PROD_W - 40;
    localparam int CFG_INDEX_W    = 3;
    localparam int FRAC_POINT     = 8;

    localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

    localparam logic [7:0] GRAY_BLANK = 8'd0;
    localparam logic [7:0] GRAY_MIN   = 8'd1;
    localparam logic [7:0] GRAY_TOP   = 8'd254;
    localparam logic [7:0] GRAY_LIMIT = 8'd255;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANK_VALUE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOG_MODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_GAIN  = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] low_limit;
        logic signed [SAMPLE_W-1:0] high_limit;
        logic signed [SAMPLE_W-1:0] blank_value;
        logic                       log_mode;
        logic [SAMPLE_W-1:0]        scale_gain;
    } cfg_t;

    typedef logic [FRAC_W-1:0] log_table_t [LOG_TABLE_SIZE];

    // log2(1 + idx / 2^LOG_TABLE_BITS) in Q0.16 by repeated squaring of a Q1.30 mantissa.
    function automatic logic [FRAC_W-1:0] log2_frac(int unsigned idx);
        logic [63:0]       m;
        logic [FRAC_W-1:0] r;
        int                k;
        m = (64'd1 << 30) + (64'(idx) << (30 - LOG_TABLE_BITS));
        r = '0;
        for (k = 0; k < FRAC_W; k++)
        begin
            m = (m * m) >> 30;
            r = {r[FRAC_W-2:0], 1'b0};
            if (m >= (64'd1 << 31))
            begin
                m    = m >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic log_table_t build_log_table();
        log_table_t t;
        int         i;
        for (i = 0; i < LOG_TABLE_SIZE; i++)
        begin
            t[i] = log2_frac(i);
        end
        return t;
    endfunction

    localparam log_table_t LOG2_FRAC_TABLE = build_log_table();

endpackage

// ===== rtl/pis_pipe.sv =====
// Seven-stage datapath: blank test and clamp, offset, products, leading one, log2, log10, gain.
module pis_pipe
    import pis_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  cfg_t                       cfg,
    output logic                       out_valid,
    output logic [7:0]                 gray_level
);

    // Valid bits of each stage.
    logic [5:0] valid_reg;
    logic       out_valid_reg;

    // Stage 1: blank test and clamp.
    logic                       blank1_reg;
    logic signed [SAMPLE_W-1:0] clamped1_reg;
    logic                       blank1_next;
    logic signed [SAMPLE_W-1:0] clamped1_next;

    // Stage 2: offset from the low limit.
    logic                       blank2_reg;
    logic                       one2_reg;
    logic [DIFF_W-1:0]          diff2_reg;
    logic signed [DIFF_W:0]     offset;
    logic                       one2_next;

    // Stage 3: linear partial products and leading-one position.
    logic                       blank3_reg;
    logic                       one3_reg;
    logic [DIFF_W-1:0]          diff3_reg;
    logic [LIN_PROD_W-1:0]      prod_hi3_reg;
    logic [LIN_PROD_W-1:0]      prod_lo3_reg;
    logic [POS_W-1:0]           pos3_reg;
    logic [POS_W-1:0]           pos3_next;

    // Stage 4: linear gray level and log2.
    logic                       blank4_reg;
    logic                       one4_reg;
    logic [7:0]                 lin4_reg;
    logic [LG2_W-1:0]           lg2_4_reg;
    logic [LIN_SUM_W-1:0]       lin_sum;
    logic [LIN_GRAY_W-1:0]      lin_gray;
    logic [7:0]                 lin4_next;
    logic [DIFF_W-1:0]          norm;
    logic [LOG_TABLE_BITS-1:0]  frac_idx;
    logic [EXP_W-1:0]           lg2_exp;

    // Stage 5: log10.
    logic                       blank5_reg;
    logic                       one5_reg;
    logic [7:0]                 lin5_reg;
    logic [LOG10_PROD_W-1:0]    lg10_prod5_reg;

    // Stage 6: gain on log10.
    logic                       blank6_reg;
    logic                       one6_reg;
    logic [7:0]                 lin6_reg;
    logic [GAIN_PROD_W-1:0]     gain_prod6_reg;
    logic [LG10_W-1:0]          lg10;

    // Output stage.
    logic [7:0]                 gray_reg;
    logic [LOG_GRAY_W-1:0]      log_gray;
    logic [7:0]                 gray_next;

    always_comb
    begin
        blank1_next   = (sample_value == cfg.blank_value);
        clamped1_next = sample_value;
        if (clamped1_next < cfg.low_limit)
        begin
            clamped1_next = cfg.low_limit;
        end
        if (clamped1_next > cfg.high_limit)
        begin
            clamped1_next = cfg.high_limit;
        end
    end

    assign offset    = (DIFF_W+1)'(clamped1_reg) - (DIFF_W+1)'(cfg.low_limit)
                     + (DIFF_W+1)'(1 << FRAC_POINT);
    assign one2_next = (offset < (DIFF_W+1)'(1 << FRAC_POINT))
                     && (cfg.log_mode || (offset <= (DIFF_W+1)'(0)));

    always_comb
    begin
        pos3_next = '0;
        for (int i = 0; i < DIFF_W; i++)
        begin
            if (diff2_reg[i])
            begin
                pos3_next = POS_W'(i);
            end
        end
    end

    assign lin_sum  = LIN_SUM_W'(prod_hi3_reg) + LIN_SUM_W'(prod_lo3_reg >> GAIN_HALF_W);
    assign lin_gray = lin_sum[LIN_SUM_W-1:GAIN_HALF_W];

    always_comb
    begin
        if (lin_gray >= LIN_GRAY_W'(GRAY_LIMIT))
        begin
            lin4_next = GRAY_TOP;
        end
        else if (lin_gray == '0)
        begin
            lin4_next = GRAY_MIN;
        end
        else
        begin
            lin4_next = lin_gray[7:0];
        end
    end

    assign norm     = diff3_reg << (POS_W'(DIFF_W - 1) - pos3_reg);
    assign frac_idx = norm[DIFF_W-2 -: LOG_TABLE_BITS];
    assign lg2_exp  = EXP_W'(pos3_reg - POS_W'(FRAC_POINT));

    assign lg10     = lg10_prod5_reg[LOG10_PROD_W-1 -: LG10_W];
    assign log_gray = gain_prod6_reg[GAIN_PROD_W-1 -: LOG_GRAY_W];

    always_comb
    begin
        if (blank6_reg)
        begin
            gray_next = GRAY_BLANK;
        end
        else if (one6_reg)
        begin
            gray_next = GRAY_MIN;
        end
        else if (!cfg.log_mode)
        begin
            gray_next = lin6_reg;
        end
        else if (log_gray >= LOG_GRAY_W'(GRAY_LIMIT))
        begin
            gray_next = GRAY_TOP;
        end
        else if (log_gray == '0)
        begin
            gray_next = GRAY_MIN;
        end
        else
        begin
            gray_next = log_gray[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[4:0], in_valid};
            out_valid_reg <= valid_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        blank1_reg     <= blank1_next;
        clamped1_reg   <= clamped1_next;

        blank2_reg     <= blank1_reg;
        one2_reg       <= one2_next;
        diff2_reg      <= offset[DIFF_W-1:0];

        blank3_reg     <= blank2_reg;
        one3_reg       <= one2_reg;
        diff3_reg      <= diff2_reg;
        prod_hi3_reg   <= LIN_PROD_W'(diff2_reg) * LIN_PROD_W'(cfg.scale_gain[31:16]);
        prod_lo3_reg   <= LIN_PROD_W'(diff2_reg) * LIN_PROD_W'(cfg.scale_gain[15:0]);
        pos3_reg       <= pos3_next;

        blank4_reg     <= blank3_reg;
        one4_reg       <= one3_reg;
        lin4_reg       <= lin4_next;
        lg2_4_reg      <= {lg2_exp, LOG2_FRAC_TABLE[frac_idx]};

        blank5_reg     <= blank4_reg;
        one5_reg       <= one4_reg;
        lin5_reg       <= lin4_reg;
        lg10_prod5_reg <= LOG10_PROD_W'(lg2_4_reg) * LOG10_PROD_W'(LOG10_2_Q32);

        blank6_reg     <= blank5_reg;
        one6_reg       <= one5_reg;
        lin6_reg       <= lin5_reg;
        gain_prod6_reg <= GAIN_PROD_W'(lg10) * GAIN_PROD_W'(cfg.scale_gain);

        gray_reg       <= gray_next;
    end

    assign out_valid  = out_valid_reg;
    assign gray_level = gray_reg;

endmodule

// ===== rtl/pixel_intensity_stretch_top.sv =====
// Top level of the pixel intensity stretch: configuration registers and the datapath.
//
// Channel        Direction  Handshake              Payload
// request        in         start high, busy low   sample_value (32, signed Q24.8)
// result         out        done for one cycle     gray_level (8, unsigned)
// configuration  in         cfg_we                 cfg_index (3), cfg_data (32)
//
// One request is taken in every clock cycle; busy is never raised.
// Each gray level passes through the seven register stages of the datapath, three of them
// multiplier stages, before it appears on the result ports.
// Reset returns the registers to their default values and empties the pipeline.
// The receiver cannot stall, so the pipeline never holds.
module pixel_intensity_stretch_top
    import pis_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    output logic                       done,
    output logic [7:0]                 gray_level,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [SAMPLE_W-1:0]        cfg_data
);

    cfg_t cfg_reg;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_limit   <= '0;
            cfg_reg.high_limit  <= 32'sd65280;
            cfg_reg.blank_value <= 32'sh8000_0000;
            cfg_reg.log_mode    <= 1'b0;
            cfg_reg.scale_gain  <= 32'h0100_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOW_LIMIT:   cfg_reg.low_limit   <= cfg_data;
                REG_HIGH_LIMIT:  cfg_reg.high_limit  <= cfg_data;
                REG_BLANK_VALUE: cfg_reg.blank_value <= cfg_data;
                REG_LOG_MODE:    cfg_reg.log_mode    <= cfg_data[0];
                REG_SCALE_GAIN:  cfg_reg.scale_gain  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    pis_pipe u_pipe
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .sample_value (sample_value),
        .cfg          (cfg_reg),
        .out_valid    (done),
        .gray_level   (gray_level)
    );

endmodule
